// ===== hw/rtl/threshold_sweep_calibrator_core_assert.svh =====
// Assertion macros shared by the threshold sweep calibrator RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef THRESHOLD_SWEEP_CALIBRATOR_CORE_ASSERT_SVH
`define THRESHOLD_SWEEP_CALIBRATOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define TSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("tsc check failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock edge.
`define TSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("tsc check failed: next-cycle implication");

`endif

// ===== hw/rtl/tsc_pkg.sv =====
// Types and constants of the threshold sweep calibrator.
// Depends on nothing; imported by every module of the block.
package tsc_pkg;

	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int OUT_DRV_W = 8;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_CAL_WAIT     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STABLE       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ERROR_TIMEOUT = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [CFG_W-1:0] CAL_WAIT_RST      = 16'd10;
	localparam logic [CFG_W-1:0] STABLE_RST        = 16'd100;
	localparam logic [CFG_W-1:0] ERROR_TIMEOUT_RST = 16'd1000;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_RISE  = 2'd1,
		PH_UPPER = 2'd2,
		PH_LOWER = 2'd3
	} cal_phase_t;

	typedef struct packed {
		logic cal_request;
		logic ref_level;
		logic ref_edge;
		logic line_level;
	} in_beat_t;

	typedef struct packed {
		logic [OUT_DRV_W-1:0] ref_drive;
		logic [OUT_DRV_W-1:0] con_drive;
		logic                 con_load;
		logic                 line_drive_high;
		logic                 error_flag;
		logic [1:0]           phase;
	} out_beat_t;

endpackage

// ===== hw/rtl/threshold_sweep_calibrator_core.sv =====
// Top level of the threshold sweep calibrator: watchdog and calibration sweep.
// Depends on tsc_pkg, tsc_out_skid and threshold_sweep_calibrator_core_assert.svh.
//
// Usage: every input beat is one one-millisecond tick carrying the comparator
// level, a comparator edge flag, the shared line level and a calibration step
// request. Each accepted beat produces exactly one result beat with the
// reference drive, the control drive, a load strobe, the line drive, the error
// flag and the calibration phase as they stand after that tick.
// Throughput is one beat per cycle while in_ready is high: the whole tick update is
// a single layer of logic from the accepted beat into the state registers and the
// result buffer. Each result is registered and offered on out_valid once any result
// ahead of it is taken. A two-entry result buffer sits on the output, so in_ready
// stays high while one result waits; it falls only when two results are held
// and the receiver is stalled, and rises again as soon as one is taken.
// Reset clears the calibration state, drives the shared line high, loads the
// configuration registers with their defaults (10, 100, 1000) and empties the
// result buffer. The configuration port writes one register per cycle with no
// wait state; writes to the unused index are ignored.
`include "threshold_sweep_calibrator_core_assert.svh"

module threshold_sweep_calibrator_core
	import tsc_pkg::*;
#(
	parameter int DRIVE_BITS = 8,
	parameter int TIME_BITS  = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_beat_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_beat_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	// Compare width wide enough for both the edge counter and a register.
	localparam int CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
	localparam logic [DRIVE_BITS-1:0] DRIVE_MAX = {DRIVE_BITS{1'b1}};
	localparam logic [TIME_BITS-1:0]  TIME_MAX  = {TIME_BITS{1'b1}};

	// Configuration registers.
	logic [CFG_W-1:0] cal_wait_q;
	logic [CFG_W-1:0] stable_q;
	logic [CFG_W-1:0] err_timeout_q;

	// Calibration state.
	cal_phase_t            phase_q, phase_n;
	logic                  err_q, err_n;
	logic                  line_driven_q, line_driven_n;
	logic [TIME_BITS-1:0]  since_edge_q, since_edge_n;
	logic [CFG_W-1:0]      wait_left_q, wait_left_n;
	logic [DRIVE_BITS-1:0] ref_value_q, ref_value_n;
	logic [DRIVE_BITS-1:0] jump_value_q, jump_value_n;
	logic [DRIVE_BITS-1:0] upper_value_q, upper_value_n;
	logic [DRIVE_BITS-1:0] mid_value_q, mid_value_n;

	logic                  in_fire;
	logic                  load;
	logic                  wd_fire;
	logic                  stable;
	logic                  step;
	logic [DRIVE_BITS:0]   mid_sum;
	logic [DRIVE_BITS-1:0] drive_up;
	logic [DRIVE_BITS-1:0] drive_down;
	out_beat_t             result;

	assign in_fire = in_valid && in_ready;

	// Register writes take effect at the edge where the enable is high.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_wait_q    <= CAL_WAIT_RST;
			stable_q      <= STABLE_RST;
			err_timeout_q <= ERROR_TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CAL_WAIT:      cal_wait_q    <= cfg_data;
				REG_STABLE:        stable_q      <= cfg_data;
				REG_ERROR_TIMEOUT: err_timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign drive_up   = (ref_value_q != DRIVE_MAX) ? ref_value_q + 1'b1 : ref_value_q;
	assign drive_down = (ref_value_q != '0) ? ref_value_q - 1'b1 : ref_value_q;
	assign mid_sum    = {1'b0, upper_value_q} + {1'b0, ref_value_q};

	// One tick: edge counter, wait countdown, watchdog, then one sweep step.
	always_comb begin
		since_edge_n  = since_edge_q;
		wait_left_n   = wait_left_q;
		phase_n       = phase_q;
		err_n         = err_q;
		line_driven_n = line_driven_q;
		ref_value_n   = ref_value_q;
		jump_value_n  = jump_value_q;
		upper_value_n = upper_value_q;
		mid_value_n   = mid_value_q;
		load          = 1'b0;

		// The edge counter saturates, so a timeout at its maximum never fires.
		if (in_data.ref_edge) begin
			since_edge_n = '0;
		end else if (since_edge_q != TIME_MAX) begin
			since_edge_n = since_edge_q + 1'b1;
		end

		if (wait_left_q != '0) begin
			wait_left_n = wait_left_q - 1'b1;
		end

		wd_fire = (CMP_W'(since_edge_n) > CMP_W'(err_timeout_q)) && !err_q;
		if (wd_fire) begin
			err_n         = 1'b1;
			phase_n       = PH_IDLE;
			line_driven_n = 1'b1;
		end

		stable = CMP_W'(since_edge_n) > CMP_W'(stable_q);
		step   = in_data.cal_request && (wait_left_n == '0);

		if (step) begin
			unique case (phase_n)
				PH_IDLE: begin
					if (err_n || !in_data.line_level) begin
						wait_left_n = cal_wait_q;
						phase_n     = PH_RISE;
					end
				end
				PH_RISE: begin
					// The first high reading marks the jump point; no wait follows it.
					if (in_data.ref_level) begin
						jump_value_n = ref_value_q;
						phase_n      = PH_UPPER;
					end else begin
						ref_value_n = drive_up;
						wait_left_n = cal_wait_q;
					end
				end
				PH_UPPER: begin
					if (stable && in_data.ref_level) begin
						phase_n       = PH_LOWER;
						upper_value_n = ref_value_q;
						ref_value_n   = jump_value_q;
					end else begin
						ref_value_n = drive_up;
					end
					wait_left_n = cal_wait_q;
				end
				PH_LOWER: begin
					if (stable && !in_data.ref_level) begin
						mid_value_n   = mid_sum[DRIVE_BITS:1];
						load          = 1'b1;
						ref_value_n   = '0;
						phase_n       = PH_IDLE;
						line_driven_n = 1'b0;
						err_n         = 1'b0;
					end else begin
						ref_value_n = drive_down;
					end
					wait_left_n = cal_wait_q;
				end
				default: ;
			endcase
		end

		result.ref_drive       = OUT_DRV_W'(ref_value_n);
		result.con_drive       = OUT_DRV_W'(mid_value_n);
		result.con_load        = load;
		result.line_drive_high = line_driven_n;
		result.error_flag      = err_n;
		result.phase           = phase_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			err_q         <= 1'b0;
			line_driven_q <= 1'b1;
			since_edge_q  <= '0;
			wait_left_q   <= '0;
			ref_value_q   <= '0;
			jump_value_q  <= '0;
			upper_value_q <= '0;
			mid_value_q   <= '0;
		end else if (in_fire) begin
			phase_q       <= phase_n;
			err_q         <= err_n;
			line_driven_q <= line_driven_n;
			since_edge_q  <= since_edge_n;
			wait_left_q   <= wait_left_n;
			ref_value_q   <= ref_value_n;
			jump_value_q  <= jump_value_n;
			upper_value_q <= upper_value_n;
			mid_value_q   <= mid_value_n;
		end
	end

	// Result buffer decouples the tick update from a stalled receiver.
	tsc_out_skid u_out_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (result),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// Input stalls only when both buffer entries are full, so a result must be waiting.
	`TSC_ASSERT_NOW(a_stall_has_result, clk, arst_n, !in_ready, out_valid)

	// A midpoint load leaves the block idle, error clear and the line released.
	`TSC_ASSERT_NEXT(a_load_releases, clk, arst_n, in_fire && load,
		(phase_q == PH_IDLE) && !err_q && !line_driven_q)

	// The watchdog never raises the error without driving the line high.
	`TSC_ASSERT_NOW(a_err_drives_line, clk, arst_n, $rose(err_q), line_driven_q)

endmodule

// ===== hw/rtl/tsc_out_skid.sv =====
// Two-entry result buffer (output register plus skid register).
// Depends on tsc_pkg for the result beat type.
module tsc_out_skid
	import tsc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  out_beat_t in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_data
);

	logic      out_valid_q;
	logic      skid_valid_q;
	out_beat_t out_data_q;
	out_beat_t skid_data_q;
	logic      push;
	logic      pop;

	assign in_ready  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign push      = in_valid && !skid_valid_q;
	assign pop       = out_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (pop) begin
					skid_valid_q <= 1'b0;
				end
			end else if (push) begin
				if (out_valid_q && !pop) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_data_q <= skid_data_q;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_data_q <= in_data;
			end else begin
				out_data_q <= in_data;
			end
		end
	end

endmodule
